>>> hdl/msh_pkg.sv
// ----------------------------------------------------------------------------
// msh_pkg
// shared constants, types and helpers for the mid-square hash table
// ----------------------------------------------------------------------------
package msh_pkg;

  localparam int NUM_BUCKETS  = 10;
  localparam int BUCKET_DEPTH = 8;

  localparam int KEY_W   = 16;
  localparam int SQ_W    = 2 * KEY_W;
  localparam int BKT_W   = 4;
  localparam int DIGIT_W = 4;
  localparam int CNT_W   = 4;
  localparam int MID_W   = 3;
  localparam int FILL_W  = $clog2(BUCKET_DEPTH + 1);
  localparam int ENTRIES = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int FOUND_W = KEY_W + 1;

  // floor(x / 10) == (x * RECIP10) >> RECIP10_SH for every 32-bit x
  localparam logic [SQ_W-1:0] RECIP10    = 32'hCCCC_CCCD;
  localparam int              RECIP10_SH = 35;

  localparam logic [SQ_W-1:0] POW10 [10] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
    32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
  };

  typedef enum logic [1:0] {
    STATUS_INSERTED  = 2'd0,
    STATUS_FOUND     = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  // result of the hash unit back to the controller
  typedef struct packed {
    logic             done;
    logic [BKT_W-1:0] bucket;
  } hash_res_t;

  // number of decimal digits of a square, zero for zero
  function automatic logic [CNT_W-1:0] digit_count(input logic [SQ_W-1:0] sq);
    logic [CNT_W-1:0] cnt;
    cnt = '0;
    for (int k = 0; k < 10; k++) begin
      if (sq >= POW10[k]) begin
        cnt = cnt + CNT_W'(1);
      end
    end
    return cnt;
  endfunction

endpackage

>>> hdl/msh_ram.sv
// ----------------------------------------------------------------------------
// msh_ram
// simple dual-port synchronous ram, registered read data
// ----------------------------------------------------------------------------
module msh_ram #(
  parameter int DEPTH  = 80,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/msh_hash.sv
// ----------------------------------------------------------------------------
// msh_hash
// iterative mid-square hash: square, count digits, peel one digit per cycle
// ----------------------------------------------------------------------------
module msh_hash
  import msh_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] key_i,
  output hash_res_t        res_o
);

  localparam logic [1:0] H_IDLE  = 2'd0;
  localparam logic [1:0] H_COUNT = 2'd1;
  localparam logic [1:0] H_DIGIT = 2'd2;

  logic [1:0]         hstate_q, hstate_d;
  logic [SQ_W-1:0]    sq_q, sq_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [MID_W-1:0]   idx_q, idx_d;
  logic [DIGIT_W-1:0] lo_q, lo_d;
  logic [BKT_W-1:0]   bkt_q, bkt_d;
  logic               done_q, done_d;

  logic [2*SQ_W-1:0]  prod;
  logic [SQ_W-1:0]    quot;
  logic [SQ_W-1:0]    quot10;
  logic [DIGIT_W-1:0] digit;
  logic [MID_W-1:0]   mid;
  logic [DIGIT_W:0]   pair_sum;

  // divide by ten through the reciprocal, remainder from the low nibble
  assign prod     = (2*SQ_W)'(sq_q) * (2*SQ_W)'(RECIP10);
  assign quot     = SQ_W'(prod >> RECIP10_SH);
  assign quot10   = (quot << 3) + (quot << 1);
  assign digit    = sq_q[DIGIT_W-1:0] - quot10[DIGIT_W-1:0];
  assign mid      = cnt_q[MID_W:1];
  assign pair_sum = {1'b0, digit} + {1'b0, lo_q};

  always_comb begin
    hstate_d = hstate_q;
    sq_d     = sq_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    lo_d     = lo_q;
    bkt_d    = bkt_q;
    done_d   = 1'b0;
    unique case (hstate_q)
      H_IDLE: begin
        if (start_i) begin
          sq_d     = SQ_W'(key_i) * SQ_W'(key_i);
          hstate_d = H_COUNT;
        end
      end
      H_COUNT: begin
        cnt_d = digit_count(sq_q);
        idx_d = '0;
        if (sq_q == '0) begin
          // zero key: no digits, bucket 0
          bkt_d    = '0;
          done_d   = 1'b1;
          hstate_d = H_IDLE;
        end else begin
          hstate_d = H_DIGIT;
        end
      end
      H_DIGIT: begin
        sq_d  = quot;
        idx_d = idx_q + MID_W'(1);
        if (idx_q == mid - MID_W'(1)) begin
          lo_d = digit;
        end
        if (idx_q == mid) begin
          if (cnt_q[0]) begin
            bkt_d = BKT_W'(digit);
          end else begin
            bkt_d = BKT_W'(pair_sum >> 1);
          end
          done_d   = 1'b1;
          hstate_d = H_IDLE;
        end
      end
      default: begin
        hstate_d = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hstate_q <= H_IDLE;
      done_q   <= 1'b0;
      bkt_q    <= '0;
    end else begin
      hstate_q <= hstate_d;
      done_q   <= done_d;
      bkt_q    <= bkt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q  <= sq_d;
    cnt_q <= cnt_d;
    idx_q <= idx_d;
    lo_q  <= lo_d;
  end

  assign res_o.done   = done_q;
  assign res_o.bucket = bkt_q;

`ifndef ASSERT_OFF
  a_bkt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> bkt_q < BKT_W'(NUM_BUCKETS))
    else $error("hash bucket out of range");

  a_done_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(hstate_q) == H_COUNT || $past(hstate_q) == H_DIGIT)
    else $error("hash done without work");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && hstate_q == H_IDLE |=> hstate_q == H_COUNT)
    else $error("hash start lost");
`endif

endmodule

>>> hdl/mid_square_hash_table.sv
// ----------------------------------------------------------------------------
// mid_square_hash_table
// chained hash table of 16-bit keys in ten buckets, insert and search
// ----------------------------------------------------------------------------
// sequence: insert and search both run the digit loop of the hash (up to six
//   digits); search then scans the bucket over the entry ram, one entry per
//   cycle, with the compare lagging the registered read data
// throughput: one item at a time, a new beat is taken once the previous
//   result sits in the output register
// reset: asynchronous active low, all buckets empty; the entry ram is not
//   cleared since only entries below a bucket's fill count are ever read
module mid_square_hash_table
  import msh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] key
  input  logic [0:0]  s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [3:0] bucket, [20:4] found_key, [23:21] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  // controller states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic OP_SEARCH = 1'b1;

  logic [2:0]        state_q, state_d;
  logic              op_q, op_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [BKT_W-1:0]  bkt_q, bkt_d;
  status_e           status_q, status_d;
  logic [FILL_W-1:0] issue_q, issue_d;
  logic              rd_vld_q, rd_vld_d;

  // per-bucket fill counts live in flops so reset empties every bucket
  logic [FILL_W-1:0] fill_q [NUM_BUCKETS];
  logic [FILL_W-1:0] fill_cur;
  logic              fill_inc;

  // output register
  logic               out_vld_q;
  status_e            out_status_q;
  logic [BKT_W-1:0]   out_bkt_q;
  logic [FOUND_W-1:0] out_found_q;
  logic               out_load;

  logic               in_fire;
  hash_res_t          hash_res;
  logic [ADDR_W-1:0]  base_addr;
  logic               ram_we;
  logic               ram_re;
  logic [KEY_W-1:0]   ram_rdata;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  msh_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .key_i   (s_axis_tdata[KEY_W-1:0]),
    .res_o   (hash_res)
  );

  assign fill_cur  = fill_q[bkt_q];
  assign base_addr = ADDR_W'(bkt_q) * ADDR_W'(BUCKET_DEPTH);

  msh_ram #(
    .DEPTH  (ENTRIES),
    .WIDTH  (KEY_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (base_addr + ADDR_W'(fill_cur)),
    .wdata_i (key_q),
    .re_i    (ram_re),
    .raddr_i (base_addr + ADDR_W'(issue_q)),
    .rdata_o (ram_rdata)
  );

  // main sequencer: hash, then insert or scan the bucket
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    key_d    = key_q;
    bkt_d    = bkt_q;
    status_d = status_q;
    issue_d  = issue_q;
    rd_vld_d = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    fill_inc = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d    = s_axis_tuser[0];
          key_d   = s_axis_tdata[KEY_W-1:0];
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_res.done) begin
          bkt_d   = hash_res.bucket;
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        if (op_q == OP_SEARCH) begin
          status_d = STATUS_NOT_FOUND;
          issue_d  = '0;
          state_d  = S_SCAN;
        end else if (fill_cur >= FILL_W'(BUCKET_DEPTH)) begin
          status_d = STATUS_FULL;
          state_d  = S_DONE;
        end else begin
          ram_we   = 1'b1;
          fill_inc = 1'b1;
          status_d = STATUS_INSERTED;
          state_d  = S_DONE;
        end
      end
      S_SCAN: begin
        // reads are issued back to back, each compare falls in the cycle after its read
        if (rd_vld_q && ram_rdata == key_q) begin
          status_d = STATUS_FOUND;
          state_d  = S_DONE;
        end else if (issue_q < fill_cur) begin
          ram_re   = 1'b1;
          rd_vld_d = 1'b1;
          issue_d  = issue_q + FILL_W'(1);
        end else if (!rd_vld_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_vld_q <= 1'b0;
      bkt_q    <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      bkt_q    <= bkt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    status_q <= status_d;
    issue_q  <= issue_d;
  end

  // fill counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        fill_q[b] <= '0;
      end
    end else if (fill_inc) begin
      fill_q[bkt_q] <= fill_cur + FILL_W'(1);
    end
  end

  // result register, parts the core from the output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      out_bkt_q    <= bkt_q;
      if (status_q == STATUS_FOUND) begin
        out_found_q <= {1'b0, key_q};
      end else begin
        out_found_q <= '1;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_found_q, out_bkt_q};
  assign m_axis_tuser  = out_status_q;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ACT |-> fill_cur <= FILL_W'(BUCKET_DEPTH))
    else $error("bucket fill beyond depth");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_inc |=> fill_q[$past(bkt_q)] == $past(fill_cur) + FILL_W'(1))
    else $error("fill count not advanced after insert");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_DONE)
    else $error("result beat without finished item");

  a_hash_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_res.done |-> state_q == S_HASH)
    else $error("hash result while controller not waiting");

  a_no_scan_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> issue_q < FILL_W'(BUCKET_DEPTH))
    else $error("scan read past bucket end");
`endif

endmodule
